/* hw/rtl/ehc_pkg.sv */
// Package for the Ethernet/IPv4/L4 header checker: payload structs,
// status codes, per-frame state record and the one's complement adder.
// No dependencies.
`default_nettype none
package ehc_pkg;

    localparam int ETH_HEADER_BYTES_DEF = 14;
    localparam int COUNT_WIDTH_DEF      = 11;
    localparam int COUNT_WIDTH_MAX      = 16;
    localparam int LEN_WIDTH            = 11;

    localparam logic [10:0] MIN_FRAME_RESET = 11'd60;
    localparam logic [10:0] MAX_FRAME_RESET = 11'd1518;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [0:0] REG_MIN_FRAME = 1'b0;
    localparam logic [0:0] REG_MAX_FRAME = 1'b1;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_ICMP      = 4'd1;
    localparam logic [3:0] ST_FRAME_LEN = 4'd2;
    localparam logic [3:0] ST_IPV6      = 4'd3;
    localparam logic [3:0] ST_VERSION   = 4'd4;
    localparam logic [3:0] ST_TOTAL     = 4'd5;
    localparam logic [3:0] ST_IHL       = 4'd6;
    localparam logic [3:0] ST_TCP_OFF   = 4'd7;
    localparam logic [3:0] ST_TCP_SHORT = 4'd8;
    localparam logic [3:0] ST_UDP_SHORT = 4'd9;

    localparam logic [1:0] L4_NONE = 2'd0;
    localparam logic [1:0] L4_UDP  = 2'd1;
    localparam logic [1:0] L4_TCP  = 2'd2;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  l4_kind;
        logic        ip_checksum_bad;
        logic        l4_checksum_bad;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [31:0] tcp_sequence;
        logic [31:0] tcp_acknowledge;
        logic [10:0] padding_length;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_WIDTH_MAX-1:0] byte_count;
        logic [3:0]  header_words;
        logic [3:0]  version_nibble;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [16:0] header_sum;
        logic [16:0] segment_sum;
        logic [7:0]  pending_high;
        logic [31:0] port_pair;
        logic [63:0] seq_ack_pair;
        logic [3:0]  tcp_offset;
        logic [15:0] udp_check;
    } frame_state_t;

    function automatic logic [16:0] ones_add(logic [16:0] s, logic [15:0] w);
        logic [17:0] t;
        t = {1'b0, s} + {2'b00, w};
        return {1'b0, t[15:0]} + {15'd0, t[17:16]};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ehc_parse.sv */
// Per-byte header parser: holds the running frame state and presents
// the state after the current byte. Depends on ehc_pkg.
`default_nettype none
module ehc_parse #(
    parameter int ETH_HEADER_BYTES = ehc_pkg::ETH_HEADER_BYTES_DEF,
    parameter int COUNT_WIDTH      = ehc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire ehc_pkg::in_item_t   item,
    output ehc_pkg::frame_state_t    state_next
);

    ehc_pkg::frame_state_t st_reg;

    function automatic logic [ehc_pkg::COUNT_WIDTH_MAX-1:0] COUNT_WIDTH_EXT(
        logic [COUNT_WIDTH-1:0] v);
        return ehc_pkg::COUNT_WIDTH_MAX'(v);
    endfunction

    always_comb
    begin
        logic [COUNT_WIDTH-1:0] p;
        logic [COUNT_WIDTH-1:0] q;
        logic [COUNT_WIDTH-1:0] s;
        logic [5:0]  hl;
        logic [7:0]  b;
        logic [15:0] w;
        ehc_pkg::frame_state_t nx;
        nx = st_reg;
        b  = item.frame_byte;
        p  = st_reg.byte_count[COUNT_WIDTH-1:0];
        q  = p - COUNT_WIDTH'(ETH_HEADER_BYTES);
        hl = '0;
        s  = '0;
        w  = '0;
        if (p != {COUNT_WIDTH{1'b1}})
        begin
            nx.byte_count = COUNT_WIDTH_EXT(p + COUNT_WIDTH'(1));
            if (p >= COUNT_WIDTH'(ETH_HEADER_BYTES))
            begin
                if (q == COUNT_WIDTH'(0))
                begin
                    nx.version_nibble = b[7:4];
                    nx.header_words   = b[3:0];
                end
                else if (q == COUNT_WIDTH'(2))
                    nx.total_length[15:8] = b;
                else if (q == COUNT_WIDTH'(3))
                    nx.total_length[7:0] = b;
                else if (q == COUNT_WIDTH'(9))
                    nx.protocol = b;
                else if (q inside {[12:15]})
                    nx.src_addr = {st_reg.src_addr[23:0], b};
                else if (q inside {[16:19]})
                    nx.dst_addr = {st_reg.dst_addr[23:0], b};

                hl = {nx.header_words, 2'b00};
                if (q < COUNT_WIDTH'(hl))
                begin
                    if (!q[0])
                        nx.pending_high = b;
                    else
                        nx.header_sum = ehc_pkg::ones_add(st_reg.header_sum,
                                                          {st_reg.pending_high, b});
                end
                else
                begin
                    s = q - COUNT_WIDTH'(hl);
                    if (s < COUNT_WIDTH'(4))
                        nx.port_pair = {st_reg.port_pair[23:0], b};
                    else if (s < COUNT_WIDTH'(12))
                        nx.seq_ack_pair = {st_reg.seq_ack_pair[55:0], b};
                    else if (s == COUNT_WIDTH'(12))
                        nx.tcp_offset = b[7:4];
                    if (s == COUNT_WIDTH'(6))
                        nx.udp_check[15:8] = b;
                    else if (s == COUNT_WIDTH'(7))
                        nx.udp_check[7:0] = b;

                    if (17'(q) < {1'b0, nx.total_length})
                    begin
                        if (!q[0])
                        begin
                            nx.pending_high = b;
                            if ((17'(q) + 17'd1) == {1'b0, nx.total_length})
                                nx.segment_sum = ehc_pkg::ones_add(st_reg.segment_sum,
                                                                   {b, 8'h00});
                        end
                        else
                        begin
                            w = {st_reg.pending_high, b};
                            if (s == COUNT_WIDTH'(7) && nx.protocol == ehc_pkg::PROTO_UDP
                                && w == 16'hffff)
                                w = 16'h0000;
                            nx.segment_sum = ehc_pkg::ones_add(st_reg.segment_sum, w);
                        end
                    end
                end
            end
        end
        state_next = nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
        begin
            if (item.frame_last)
                st_reg <= '0;
            else
                st_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ehc_finish.sv */
// End-of-frame evaluation: length checks, IPv4 checks and the L4
// pseudo-header checksum over a captured frame state. Depends on ehc_pkg.
`default_nettype none
module ehc_finish #(
    parameter int ETH_HEADER_BYTES = ehc_pkg::ETH_HEADER_BYTES_DEF,
    parameter int COUNT_WIDTH      = ehc_pkg::COUNT_WIDTH_DEF
) (
    input  wire ehc_pkg::frame_state_t snap,
    input  wire logic [10:0]           min_len,
    input  wire logic [10:0]           max_len,
    output ehc_pkg::out_item_t         result
);

    always_comb
    begin
        logic [15:0] len;
        logic [15:0] ipbytes;
        logic [5:0]  hl;
        logic [5:0]  off;
        logic [15:0] dl;
        logic [18:0] ps_wide;
        logic [16:0] ps_fold;
        logic [15:0] ps;
        logic        l4_bad;
        ehc_pkg::out_item_t r;
        r   = '0;
        len = 16'(snap.byte_count[COUNT_WIDTH-1:0]);
        hl  = {snap.header_words, 2'b00};
        off = {snap.tcp_offset, 2'b00};
        dl  = snap.total_length - 16'(hl);
        ipbytes = (len >= 16'(ETH_HEADER_BYTES)) ? len - 16'(ETH_HEADER_BYTES) : 16'd0;

        // sum all pseudo-header terms at full width, then fold the carries
        ps_wide = ((19'(snap.segment_sum) + 19'(snap.src_addr[31:16]))
                   + (19'(snap.src_addr[15:0]) + 19'(snap.dst_addr[31:16])))
                  + ((19'(snap.dst_addr[15:0]) + 19'(snap.protocol)) + 19'(dl));
        ps_fold = 17'(ps_wide[15:0]) + 17'(ps_wide[18:16]);
        ps      = ps_fold[15:0] + 16'(ps_fold[16]);
        l4_bad  = (ps != 16'hffff);

        if (len < {5'd0, min_len} || len > {5'd0, max_len})
            r.status = ehc_pkg::ST_FRAME_LEN;
        else if (snap.version_nibble == 4'd6)
            r.status = ehc_pkg::ST_IPV6;
        else if (snap.version_nibble != 4'd4)
            r.status = ehc_pkg::ST_VERSION;
        else if (snap.total_length > ipbytes)
            r.status = ehc_pkg::ST_TOTAL;
        else
        begin
            r.padding_length = 11'(ipbytes - snap.total_length);
            if (hl < 6'd20 || 16'(hl) > snap.total_length)
                r.status = ehc_pkg::ST_IHL;
            else
            begin
                r.ip_checksum_bad     = (snap.header_sum != 17'h0ffff);
                r.ip_protocol         = snap.protocol;
                r.source_address      = snap.src_addr;
                r.destination_address = snap.dst_addr;
                if (dl != 16'd0)
                begin
                    if (snap.protocol == ehc_pkg::PROTO_ICMP)
                        r.status = ehc_pkg::ST_ICMP;
                    else if (snap.protocol == ehc_pkg::PROTO_TCP)
                    begin
                        r.l4_kind = ehc_pkg::L4_TCP;
                        if (off < 6'd20)
                            r.status = ehc_pkg::ST_TCP_OFF;
                        else if (dl < 16'(off))
                            r.status = ehc_pkg::ST_TCP_SHORT;
                        else
                        begin
                            r.l4_checksum_bad  = l4_bad;
                            r.source_port      = snap.port_pair[31:16];
                            r.destination_port = snap.port_pair[15:0];
                            r.tcp_sequence     = snap.seq_ack_pair[63:32];
                            r.tcp_acknowledge  = snap.seq_ack_pair[31:0];
                        end
                    end
                    else if (snap.protocol == ehc_pkg::PROTO_UDP)
                    begin
                        r.l4_kind          = ehc_pkg::L4_UDP;
                        r.source_port      = snap.port_pair[31:16];
                        r.destination_port = snap.port_pair[15:0];
                        if (dl < 16'd8)
                            r.status = ehc_pkg::ST_UDP_SHORT;
                        else if (snap.udp_check != 16'd0)
                            r.l4_checksum_bad = l4_bad;
                    end
                end
            end
        end
        result = r;
    end

endmodule
`default_nettype wire

/* hw/rtl/ethernet_ipv4_l4_header_checker_unit.sv */
// Top level of the Ethernet/IPv4/L4 header checker.
// Depends on ehc_pkg, ehc_parse and ehc_finish.
//
//  channel | signals                     | moves
//  in      | in_valid/in_ready/in_item   | one frame byte per item
//  out     | out_valid/out_ready/out_item| one status item per frame
//  cfg     | cfg_we/cfg_index/cfg_data   | frame length bounds
//
// One byte is taken per cycle while in_ready is high. The byte marked last copies
// the frame state into a snapshot register; once the output register is free,
// the snapshot is evaluated into it and the status item becomes valid.
// Reset clears the parser's frame state and the valid flags, the bounds return to 60 and 1518.
// A held output stalls input only once the snapshot slot is also full.
`default_nettype none
module ethernet_ipv4_l4_header_checker_unit #(
    parameter int ETH_HEADER_BYTES = ehc_pkg::ETH_HEADER_BYTES_DEF,
    parameter int COUNT_WIDTH      = ehc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ehc_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ehc_pkg::out_item_t      out_item,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [10:0]        cfg_data
);

    logic [10:0] min_len_reg;
    logic [10:0] max_len_reg;
    logic        snap_valid_reg;
    logic        out_valid_reg;
    ehc_pkg::frame_state_t snap_reg;
    ehc_pkg::frame_state_t state_next;
    ehc_pkg::out_item_t    result_next;
    ehc_pkg::out_item_t    out_reg;
    logic accept;
    logic out_free;
    logic move;

    assign out_free = !out_valid_reg || out_ready;
    assign move     = snap_valid_reg && out_free;
    assign in_ready = !snap_valid_reg || out_free;
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    ehc_parse #(
        .ETH_HEADER_BYTES(ETH_HEADER_BYTES),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_parse (
        .clk(clk),
        .rst_n(rst_n),
        .advance(accept),
        .item(in_item),
        .state_next(state_next)
    );

    ehc_finish #(
        .ETH_HEADER_BYTES(ETH_HEADER_BYTES),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_finish (
        .snap(snap_reg),
        .min_len(min_len_reg),
        .max_len(max_len_reg),
        .result(result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg    <= ehc_pkg::MIN_FRAME_RESET;
            max_len_reg    <= ehc_pkg::MAX_FRAME_RESET;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ehc_pkg::REG_MIN_FRAME: min_len_reg <= cfg_data;
                    ehc_pkg::REG_MAX_FRAME: max_len_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && in_item.frame_last)
                snap_valid_reg <= 1'b1;
            else if (move)
                snap_valid_reg <= 1'b0;
            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_item.frame_last)
            snap_reg <= state_next;
        if (move)
            out_reg <= result_next;
    end

endmodule
`default_nettype wire
